### rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg - shared definitions for the point in polygon test core
// Operation codes, fixed port widths, parameter defaults and the control and
// status bundles passed between the sequencer and the edge cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  // parameter defaults
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 32;

  // fixed port widths
  localparam int PORT_COORD_W = 32;
  localparam int INDEX_W      = 6;
  localparam int CFG_W        = 7;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // sequencer to edge cell chain
  typedef struct packed {
    logic clear;     // start of a test, clear the parity
    logic edge_vld;  // an edge enters the chain this cycle
  } ppt_ctrl_t;

  // edge cell chain back to sequencer
  typedef struct packed {
    logic busy;      // an edge is still moving through the chain
    logic parity;    // running crossing parity
  } ppt_stat_t;

endpackage

`default_nettype wire

### rtl/ppt_ram.sv
// ----------------------------------------------------------------------------
// ppt_ram - generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/ppt_edge_pipe.sv
// ----------------------------------------------------------------------------
// ppt_edge_pipe - chain of edge cells
// Difference cell, product cell and compare cell; each hands one edge to the
// next per cycle. The last cell folds the crossing decision into the parity.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_edge_pipe #(
  parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ppt_pkg::ppt_ctrl_t            ctrl,
  input  wire logic signed [COORD_WIDTH-1:0] px,
  input  wire logic signed [COORD_WIDTH-1:0] py,
  input  wire logic signed [COORD_WIDTH-1:0] xi,
  input  wire logic signed [COORD_WIDTH-1:0] yi,
  input  wire logic signed [COORD_WIDTH-1:0] xj,
  input  wire logic signed [COORD_WIDTH-1:0] yj,
  output ppt_pkg::ppt_stat_t                 stat
);

  import ppt_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // difference cell
  logic signed [DW-1:0] a1_c, d_c, a2_c, b2_c;
  logic                 str_c;
  logic                 s1_vld, s1_str;
  logic signed [DW-1:0] s1_a1, s1_d, s1_a2, s1_b2;

  // product cell
  logic signed [PW-1:0] p1_c, p2_c;
  logic                 s2_vld, s2_str, s2_dpos, s2_dneg;
  logic signed [PW-1:0] s2_p1, s2_p2;

  // compare cell
  logic                 cross_c;
  logic                 parity;

  // edge straddles the ray line, and the differences
  always_comb begin
    str_c = (yi > py) != (yj > py);
    a1_c  = {px[COORD_WIDTH-1], px} - {xi[COORD_WIDTH-1], xi};
    d_c   = {yj[COORD_WIDTH-1], yj} - {yi[COORD_WIDTH-1], yi};
    a2_c  = {xj[COORD_WIDTH-1], xj} - {xi[COORD_WIDTH-1], xi};
    b2_c  = {py[COORD_WIDTH-1], py} - {yi[COORD_WIDTH-1], yi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ctrl.edge_vld;
    end
    s1_str <= str_c;
    s1_a1  <= a1_c;
    s1_d   <= d_c;
    s1_a2  <= a2_c;
    s1_b2  <= b2_c;
  end

  // exact cross products
  assign p1_c = s1_a1 * s1_d;
  assign p2_c = s1_a2 * s1_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_str  <= s1_str;
    s2_dpos <= !s1_d[DW-1] && (s1_d != '0);
    s2_dneg <= s1_d[DW-1];
    s2_p1   <= p1_c;
    s2_p2   <= p2_c;
  end

  // compare direction follows the sign of the y difference
  assign cross_c = s2_vld && s2_str &&
                   ((s2_dpos && (s2_p1 < s2_p2)) || (s2_dneg && (s2_p1 > s2_p2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (ctrl.clear) begin
      parity <= 1'b0;
    end else begin
      parity <= parity ^ cross_c;
    end
  end

  assign stat.busy   = s1_vld | s2_vld;
  assign stat.parity = parity;

endmodule

`default_nettype wire

### rtl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core - crossing number point in polygon test
// Loads polygon vertices into a vertex ram and answers test transactions
// with the parity of edge crossings of a ray in the positive x direction.
//
//   channel   signals                                   direction
//   input     in_valid in_ready op vertex_index coord_*  in
//   output    out_valid out_ready inside_res             out
//   config    cfg_we cfg_wdata                           in
//
// A load is written into the vertex ram as it is accepted. A test with n
// vertices makes n + 1 reads of the single vertex ram read port, one edge per
// cycle, then empties the edge cell chain and loads the result into the output
// register when it is free. A test with a vertex count of zero skips the reads.
// Reset is synchronous and clears control state; the ram is not cleared.
// A finished result waits in the output register while loads are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = ppt_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic                                     op,
  input  wire logic        [ppt_pkg::INDEX_W-1:0]       vertex_index,
  input  wire logic signed [ppt_pkg::PORT_COORD_W-1:0]  coord_x,
  input  wire logic signed [ppt_pkg::PORT_COORD_W-1:0]  coord_y,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          inside_res,
  input  wire logic                                     cfg_we,
  input  wire logic        [ppt_pkg::CFG_W-1:0]         cfg_wdata
);

  import ppt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VW     = 2 * COORD_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                    state;
  logic [CFG_W-1:0]              vertex_count;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;
  logic [CNT_W-1:0]              n_lat, n_in, rd_cnt, rd_sel;
  logic                          rd_vld, rd_first;
  logic                          in_acc, out_acc, test_go, load_we, fin_load;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic [VW-1:0]                 wr_data, rd_data;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  ppt_ctrl_t                     ctrl;
  ppt_stat_t                     stat;

  // handshakes
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign test_go  = in_acc && (op == OP_TEST);
  assign load_we  = in_acc && (op == OP_LOAD) && (32'(vertex_index) < MAX_VERTICES);
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ready);

  // vertex count clamped to the store depth
  assign n_in = (32'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                   : CNT_W'(vertex_count);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // vertex ram: write on load, read last vertex first then 0 .. n-1
  assign wr_addr = ADDR_W'(vertex_index);
  assign wr_data = {coord_y[COORD_WIDTH-1:0], coord_x[COORD_WIDTH-1:0]};
  assign rd_en   = (state == ST_RUN);
  assign rd_sel  = (rd_cnt == '0) ? (n_lat - CNT_W'(1)) : (rd_cnt - CNT_W'(1));
  assign rd_addr = rd_sel[ADDR_W-1:0];

  ppt_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_vram (
    .clk   (clk),
    .we    (load_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_x = rd_data[COORD_WIDTH-1:0];
  assign rd_y = rd_data[VW-1:COORD_WIDTH];

  // edge cell chain
  assign ctrl.clear    = test_go;
  assign ctrl.edge_vld = rd_vld && !rd_first;

  ppt_edge_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .px   (px),
    .py   (py),
    .xi   (rd_x),
    .yi   (rd_y),
    .xj   (prev_x),
    .yj   (prev_y),
    .stat (stat)
  );

  // read tracking and previous vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
    rd_first <= (rd_cnt == '0);
    if (rd_vld) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  // test sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (test_go) begin
            state <= (n_in == '0) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd_cnt == n_lat) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld && !stat.busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // test point, count and read counter
  always_ff @(posedge clk) begin
    if (test_go) begin
      px     <= coord_x[COORD_WIDTH-1:0];
      py     <= coord_y[COORD_WIDTH-1:0];
      n_lat  <= n_in;
      rd_cnt <= '0;
    end else if (rd_en) begin
      rd_cnt <= rd_cnt + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
    if (fin_load) begin
      inside_res <= stat.parity;
    end
  end

endmodule

`default_nettype wire

### rtl/ppt_checker.sv
// ----------------------------------------------------------------------------
// ppt_checker - port level checks for the point in polygon test core
// Watches the top level ports and is bound to every instance of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic inside_res
);

  import ppt_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result changed while stalled");

  // a test transaction keeps the input side closed the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_TEST) |=> !in_ready)
    else $error("input accepted right after a test");

  // a load never produces a result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result after a load");

  // reset leaves the core idle with no result
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("core not idle after reset");

endmodule

bind point_in_polygon_test_core ppt_checker u_ppt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .op         (op),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .inside_res (inside_res)
);

`default_nettype wire

### verif/point_in_polygon_test_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_test - self-checking bench for the polygon core
// Loads polygons into the vertex store and fires test points at them, with
// random idle gaps on the input side and random stalls on the output side.
// Answers are checked against typed values or a bit-exact crossing parity here.
// A short directed table comes first, then random polygon phases.
// ----------------------------------------------------------------------------

module point_in_polygon_test_core_test;
  import ppt_pkg::*;

  localparam int MAX_V        = MAX_VERTICES_DEF;
  localparam int RANDOM_ITEMS = 340;
  localparam int LOAD_SETTLE  = 4;
  localparam int TEST_LATENCY = MAX_V + 8;
  localparam int MIXED_ITEMS  = 30;

  localparam logic signed [PORT_COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [PORT_COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  typedef enum logic {ROW_TXN, ROW_CFG} row_kind_t;

  typedef enum int {SHAPE_SMALL, SHAPE_MEDIUM, SHAPE_LEVELS, SHAPE_EXTREME, SHAPE_FULL} shape_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic                            row_op;
    logic [INDEX_W-1:0]              idx;
    logic signed [PORT_COORD_W-1:0]  x;
    logic signed [PORT_COORD_W-1:0]  y;
    logic [CFG_W-1:0]                count;
    logic                            typed;
    logic                            want;
  } dir_row_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic                            op;
  logic [INDEX_W-1:0]              vertex_index;
  logic signed [PORT_COORD_W-1:0]  coord_x;
  logic signed [PORT_COORD_W-1:0]  coord_y;
  logic                            out_valid;
  logic                            out_ready;
  logic                            inside_res;
  logic                            cfg_we;
  logic [CFG_W-1:0]                cfg_wdata;

  // local copy of the polygon and the vertex count
  logic signed [PORT_COORD_W-1:0]  poly_x [MAX_V];
  logic signed [PORT_COORD_W-1:0]  poly_y [MAX_V];
  logic [CFG_W-1:0]                poly_count;

  logic                            inside_expected [$];
  dir_row_t                        dir_table [$];
  int                              mismatch_count = 0;
  int                              send_gap_pct   = 0;
  int                              stall_pct      = 0;
  logic                            want_inside;

  point_in_polygon_test_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .inside_res   (inside_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // crossing parity of a ray from (px, py) toward +x, exact in wide integers
  function automatic logic point_inside(input logic signed [PORT_COORD_W-1:0] px,
                                        input logic signed [PORT_COORD_W-1:0] py);
    int n;
    int i;
    int j;
    logic hit;
    logic signed [69:0] xi, yi, xj, yj, dy, cross_val;
    hit = 1'b0;
    n = (poly_count > MAX_V) ? MAX_V : int'(poly_count);
    j = n - 1;
    for (i = 0; i < n; i++) begin
      // only edges that straddle the ray's line can be crossed
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        xi = 70'(poly_x[i]);
        yi = 70'(poly_y[i]);
        xj = 70'(poly_x[j]);
        yj = 70'(poly_y[j]);
        dy = yj - yi;
        cross_val = (px - xi) * dy - (xj - xi) * (py - yi);
        if ((dy > 0 && cross_val < 0) || (dy < 0 && cross_val > 0)) hit = ~hit;
      end
      j = i;
    end
    return hit;
  endfunction

  // one coordinate drawn to suit the polygon's shape
  function automatic logic signed [PORT_COORD_W-1:0] shape_coord(input shape_t s,
                                                                 input bit is_y);
    case (s)
      SHAPE_SMALL:  return int'($urandom_range(64)) - 32;
      SHAPE_MEDIUM: return int'($urandom_range(2097152)) - 1048576;
      SHAPE_LEVELS: begin
        if (is_y) return 8 * (int'($urandom_range(4)) - 2);
        return int'($urandom_range(64)) - 32;
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(3))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  function automatic dir_row_t txn_row(input logic o, input int i, input int x, input int y,
                                       input bit typed, input logic want);
    dir_row_t r;
    r = '0;
    r.kind   = ROW_TXN;
    r.row_op = o;
    r.idx    = INDEX_W'(i);
    r.x      = x;
    r.y      = y;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input int c);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.count = CFG_W'(c);
    return r;
  endfunction

  // present one transaction, wait for acceptance, update polygon or expected queue
  task automatic issue_txn(input logic t_op, input logic [INDEX_W-1:0] t_idx,
                           input logic signed [PORT_COORD_W-1:0] t_x,
                           input logic signed [PORT_COORD_W-1:0] t_y,
                           input bit typed, input logic want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= t_op;
    vertex_index <= t_idx;
    coord_x      <= t_x;
    coord_y      <= t_y;
    do @(posedge clk); while (!in_ready);
    if (t_op == OP_LOAD) begin
      poly_x[t_idx] = t_x;
      poly_y[t_idx] = t_y;
    end else begin
      inside_expected.push_back(typed ? want : point_inside(t_x, t_y));
    end
  endtask

  // hold off until every answer is back and a trailing load has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (inside_expected.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    poly_count = val;
  endtask

  // output side: random stalls
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (inside_expected.size() == 0) begin
        $error("inside_res: no result pending, got %0b", inside_res);
        mismatch_count++;
      end else begin
        want_inside = inside_expected.pop_front();
        if (inside_res !== want_inside) begin
          $error("inside_res: expected %0b, got %0b", want_inside, inside_res);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    int k;
    int phase;
    int rand_items;
    int n_used;
    int count;
    shape_t shape;
    logic signed [PORT_COORD_W-1:0] tx, ty;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= OP_LOAD;
    vertex_index <= '0;
    coord_x      <= '0;
    coord_y      <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    poly_count   = '0;
    rand_items   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty polygon, a square, tiny counts, a corner-to-corner triangle
    dir_table.push_back(txn_row(OP_TEST, 0, 0, 0, 1, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, C_MAX, C_MIN, 1, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 0, -10, -10, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 1, 10, -10, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 2, 10, 10, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 3, -10, 10, 0, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, 0, 0, 1, 1'b0));
    dir_table.push_back(cfg_row(4));
    dir_table.push_back(txn_row(OP_TEST, 63, 0, 0, 1, 1'b1));
    dir_table.push_back(txn_row(OP_TEST, 0, 20, 0, 1, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, -20, 0, 0, 1'b0));
    // points on the top edge, the right edge and the bottom edge
    dir_table.push_back(txn_row(OP_TEST, 0, 0, 10, 0, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, 10, 0, 0, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, 0, -10, 0, 1'b0));
    dir_table.push_back(cfg_row(1));
    dir_table.push_back(txn_row(OP_TEST, 0, -20, -10, 1, 1'b0));
    dir_table.push_back(cfg_row(2));
    dir_table.push_back(txn_row(OP_TEST, 0, 0, 0, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 63, C_MAX, C_MIN, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 0, C_MIN, C_MIN, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 1, C_MAX, C_MIN, 0, 1'b0));
    dir_table.push_back(txn_row(OP_LOAD, 2, 0, C_MAX, 0, 1'b0));
    dir_table.push_back(cfg_row(3));
    dir_table.push_back(txn_row(OP_TEST, 0, 0, 0, 1, 1'b1));
    dir_table.push_back(txn_row(OP_TEST, 0, C_MAX, C_MAX, 1, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, C_MIN, 0, 0, 1'b0));
    dir_table.push_back(txn_row(OP_TEST, 0, C_MIN, C_MIN, 0, 1'b0));

    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CFG) begin
        drain_results();
        set_vertex_count(dir_table[r].count);
      end else begin
        issue_txn(dir_table[r].row_op, dir_table[r].idx, dir_table[r].x, dir_table[r].y,
                  dir_table[r].typed, dir_table[r].want);
      end
    end

    // fill the whole store so that any count reads only written vertices
    for (k = 0; k < MAX_V; k++) begin
      issue_txn(OP_LOAD, INDEX_W'(k), $urandom, $urandom, 0, 1'b0);
      rand_items++;
    end

    // random phases: new polygon, new count, then a mix of tests and loads
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 21; stall_pct = 21; end
      endcase
      case (phase)
        0: count = MAX_V;
        1: count = 127;
        2: count = 0;
        3: count = 1;
        4: count = 2;
        5: count = 3;
        6: count = 100;
        default: count = ($urandom_range(4) == 0) ? $urandom_range(13, MAX_V)
                                                  : $urandom_range(3, 12);
      endcase
      n_used = (count > MAX_V) ? MAX_V : count;
      shape  = shape_t'($urandom_range(4));

      for (k = 0; k < n_used; k++) begin
        issue_txn(OP_LOAD, INDEX_W'(k), shape_coord(shape, 0), shape_coord(shape, 1),
                  0, 1'b0);
        rand_items++;
      end
      drain_results();
      set_vertex_count(CFG_W'(count));

      repeat (MIXED_ITEMS) begin
        if ($urandom_range(99) < 20) begin
          issue_txn(OP_LOAD, INDEX_W'($urandom_range(MAX_V - 1)), shape_coord(shape, 0),
                    shape_coord(shape, 1), 0, 1'b0);
        end else begin
          k = $urandom_range((n_used > 0) ? n_used - 1 : 0);
          case ($urandom_range(9))
            // level with a vertex, at most two away from it in x
            5, 6: begin
              tx = poly_x[k] + int'($urandom_range(4)) - 2;
              ty = poly_y[k];
            end
            // exactly on a vertex
            7: begin
              tx = poly_x[k];
              ty = poly_y[k];
            end
            8: begin
              tx = $urandom;
              ty = $urandom;
            end
            9: begin
              tx = shape_coord(SHAPE_EXTREME, 0);
              ty = shape_coord(SHAPE_EXTREME, 1);
            end
            default: begin
              tx = shape_coord(shape, 0);
              ty = shape_coord(shape, 1);
            end
          endcase
          issue_txn(OP_TEST, INDEX_W'($urandom_range(MAX_V - 1)), tx, ty, 0, 1'b0);
        end
        rand_items++;
      end
      phase++;
    end

    // let the last answers come back, then a full test time more
    drain_results();
    repeat (TEST_LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ppt_pkg.sv
rtl/ppt_ram.sv
rtl/ppt_edge_pipe.sv
rtl/point_in_polygon_test_core.sv
rtl/ppt_checker.sv
verif/point_in_polygon_test_core_test.sv
